// ===== rtl/core/xdv_pkg.sv =====
// Shared types, codes and constants for the XOR-delta viewport decoder.
// Depends on nothing; used by xor_delta_viewport_decoder.
package xdv_pkg;

	// Default frame store size in bytes (a power of two)
	localparam int FRAME_BYTES_DEF = 65536;

	// Result queue depth; bounds the results owed to the receiver
	localparam int OUT_DEPTH = 4;

	// Input operation kinds
	localparam logic [1:0] OP_DELTA = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_COPY_MODE  = 2'd0;
	localparam logic [1:0] CFG_ROW_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_ROW_PITCH  = 2'd2;
	localparam logic [1:0] CFG_START_ADDR = 2'd3;

	// Configuration reset values
	localparam logic [12:0] ROW_WIDTH_RST = 13'd320;
	localparam logic [15:0] ROW_PITCH_RST = 16'd320;

	// Command byte codes and count masks
	localparam logic [7:0]  CMD_LONG      = 8'h80;
	localparam logic [7:0]  CMD_SKIP_MASK = 8'h7F;
	localparam logic [12:0] ROW_WIDTH_MAX = 13'd4096;

	// Delta parser phase
	typedef enum logic [7:0] {
		PH_FRAME     = 8'b0000_0001,
		PH_CMD       = 8'b0000_0010,
		PH_SFILL_CNT = 8'b0000_0100,
		PH_SFILL_VAL = 8'b0000_1000,
		PH_LITERAL   = 8'b0001_0000,
		PH_LONG_LO   = 8'b0010_0000,
		PH_LONG_HI   = 8'b0100_0000,
		PH_LFILL_VAL = 8'b1000_0000
	} phase_t;

	// Multi-cycle engine: fill walk and skip (divide, multiply, add)
	typedef enum logic [4:0] {
		ENG_IDLE = 5'b00001,
		ENG_FILL = 5'b00010,
		ENG_DIV  = 5'b00100,
		ENG_MUL  = 5'b01000,
		ENG_ADD  = 5'b10000
	} eng_t;

	// Control flags of one store access launched toward the memory
	typedef struct packed {
		logic       valid;
		logic       emit;   // this access carries the item's result
		logic       done;   // result closes a frame
		logic       wr;     // write the store
		logic       xr;     // XOR with the stored byte
		logic       rd;     // return the stored byte
		logic       adv;    // advance the write position
		logic [7:0] val;
	} launch_t;

	// One result beat
	typedef struct packed {
		logic       last;
		logic [7:0] data;
	} res_t;

	// Clamp the row width to 1..4096
	function automatic logic [12:0] eff_width(input logic [12:0] rw);
		logic [12:0] w;
		begin
			w = rw;
			if (rw == 13'd0) begin
				w = 13'd1;
			end else if (rw > ROW_WIDTH_MAX) begin
				w = ROW_WIDTH_MAX;
			end
			return w;
		end
	endfunction

endpackage

// ===== rtl/core/xdv_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// A read at the written address returns the old data. No dependencies.
module xdv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/xor_delta_viewport_decoder.sv =====
// XOR-delta viewport decoder top level: parser, fill/skip engine, store access
// stage and result queue. Depends on xdv_pkg and xdv_ram.
//
// Usage:
//  Input beats arrive on s_tvalid/s_tready with the operation kind in s_tuser
//  (0 delta byte, 1 store write, 2 store read). Every input beat yields exactly
//  one result beat on m_tvalid/m_tready: m_tdata carries the stored byte for a
//  read (zero otherwise), m_tlast marks the delta byte that ended a frame.
//  A result is registered in the access stage and then in the result queue
//  after its input beat or the last byte of a fill. Literal bytes, store
//  writes and store reads are taken one per cycle while s_tready is high; the
//  XOR read-modify-write uses the store's registered read with forwarding from
//  the previous write. A fill of n bytes holds s_tready low while it walks the
//  store one byte a cycle. A skip holds s_tready low through 16 radix-2 divide
//  steps by the row width, one multiply by the row pitch and one pointer add.
//  The result queue holds four beats; when the receiver stalls, input is taken
//  until four results are owed, then s_tready drops. Reset clears the parser,
//  engine, queue and configuration registers to their defaults; frame store
//  contents are not cleared. Configuration writes are taken every cycle on
//  cfg_we; writing them only while idle is up to the user.
module xor_delta_viewport_decoder #(
	parameter int FRAME_BYTES = xdv_pkg::FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] data, [23:8] address
	input  logic [1:0]  s_tuser,   // [1:0] op
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] read_data
	output logic        m_tlast    // frame_done
);

	localparam int AW  = $clog2(FRAME_BYTES);
	localparam int QD  = xdv_pkg::OUT_DEPTH;
	localparam int QPW = $clog2(QD);
	localparam int QCW = $clog2(QD + 1);

	// Configuration registers
	logic        copy_q;
	logic [12:0] row_width_q;
	logic [15:0] pitch_q;
	logic [15:0] start_q;
	logic [12:0] w;

	// Parser and position state
	xdv_pkg::phase_t phase_q, phase_d;
	xdv_pkg::eng_t   eng_q;
	logic [14:0]     run_cnt_q, run_d;
	logic [7:0]      fill_q, fill_d;
	logic [7:0]      lo_q, lo_d;
	logic [AW-1:0]   wp_q;
	logic [11:0]     col_q;

	// Skip divider and multiplier
	logic [15:0] quo_q;
	logic [11:0] rem_q;
	logic [3:0]  div_cnt_q;
	logic [31:0] prod_q;
	logic [12:0] trial;
	logic        trial_ge;
	logic [11:0] rem_next;

	// Launch decode
	xdv_pkg::launch_t l;
	logic [AW-1:0]    l_addr;
	logic             acc, take;
	logic             fill_go, skip_go, frame_go;
	logic [15:0]      skip_n, skip_total;
	logic [15:0]      long_n;
	logic [AW-1:0]    base_wp;
	logic [11:0]      base_col;
	logic [12:0]      col1;
	logic             col_wrap;
	logic [AW-1:0]    wp_adv;
	logic [11:0]      col_adv;

	// Store access stage
	logic          v_s1, emit_s1, done_s1, wr_s1, xr_s1, rd_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    val_s1;
	logic [7:0]    ram_rdata, cur_byte, wdata;
	logic          we;
	logic          fwd_v_q;
	logic [AW-1:0] fwd_addr_q;
	logic [7:0]    fwd_data_q;

	// Result queue
	xdv_pkg::res_t  q_mem [QD];
	xdv_pkg::res_t  q_head;
	logic [QPW-1:0] q_wr_q, q_rd_q;
	logic [QCW-1:0] q_cnt_q;
	logic [QCW-1:0] pend_q;
	logic           push;

	assign w    = xdv_pkg::eff_width(row_width_q);
	assign acc  = s_tvalid && s_tready;
	assign take = m_tvalid && m_tready;

	// Accept only when the engine is free and a result slot is left
	assign s_tready = (eng_q == xdv_pkg::ENG_IDLE) && (pend_q < QCW'(QD));

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_q      <= 1'b0;
			row_width_q <= xdv_pkg::ROW_WIDTH_RST;
			pitch_q     <= xdv_pkg::ROW_PITCH_RST;
			start_q     <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				xdv_pkg::CFG_COPY_MODE:  copy_q      <= cfg_data[0];
				xdv_pkg::CFG_ROW_WIDTH:  row_width_q <= cfg_data[12:0];
				xdv_pkg::CFG_ROW_PITCH:  pitch_q     <= cfg_data;
				xdv_pkg::CFG_START_ADDR: start_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Position after one written byte: next column or next row start
	assign col1     = {1'b0, col_q} + 13'd1;
	assign col_wrap = col1 >= w;
	assign wp_adv   = col_wrap ? (wp_q + AW'(pitch_q) - AW'(col_q)) : (wp_q + AW'(1));
	assign col_adv  = col_wrap ? 12'd0 : col1[11:0];

	// Frame start replaces the position before the command acts
	assign base_wp    = (phase_q == xdv_pkg::PH_FRAME) ? AW'(start_q) : wp_q;
	assign base_col   = (phase_q == xdv_pkg::PH_FRAME) ? 12'd0 : col_q;
	assign skip_total = {4'd0, base_col} + skip_n;
	assign long_n     = {s_tdata[7:0], lo_q};

	// Decode the accepted beat or the next fill byte into a store access
	always_comb begin
		l        = '0;
		l_addr   = AW'(s_tdata[23:8]);
		phase_d  = phase_q;
		run_d    = run_cnt_q;
		fill_d   = fill_q;
		lo_d     = lo_q;
		fill_go  = 1'b0;
		skip_go  = 1'b0;
		frame_go = 1'b0;
		skip_n   = 16'd0;
		if (acc) begin
			l.valid = 1'b1;
			l.emit  = 1'b1;
			l.val   = s_tdata[7:0];
			case (s_tuser)
				xdv_pkg::OP_WRITE: l.wr = 1'b1;
				xdv_pkg::OP_READ:  l.rd = 1'b1;
				xdv_pkg::OP_DELTA: begin
					case (phase_q)
						xdv_pkg::PH_FRAME, xdv_pkg::PH_CMD: begin
							frame_go = (phase_q == xdv_pkg::PH_FRAME);
							phase_d  = xdv_pkg::PH_CMD;
							if (s_tdata[7:0] == 8'd0) begin
								phase_d = xdv_pkg::PH_SFILL_CNT;
							end else if (s_tdata[7:0] < xdv_pkg::CMD_LONG) begin
								run_d   = 15'(s_tdata[7:0]);
								phase_d = xdv_pkg::PH_LITERAL;
							end else if (s_tdata[7:0] == xdv_pkg::CMD_LONG) begin
								phase_d = xdv_pkg::PH_LONG_LO;
							end else begin
								skip_go = 1'b1;
								skip_n  = 16'(s_tdata[7:0] & xdv_pkg::CMD_SKIP_MASK);
							end
						end
						xdv_pkg::PH_SFILL_CNT: begin
							run_d   = 15'(s_tdata[7:0]);
							phase_d = xdv_pkg::PH_SFILL_VAL;
						end
						xdv_pkg::PH_SFILL_VAL, xdv_pkg::PH_LFILL_VAL: begin
							fill_d  = s_tdata[7:0];
							phase_d = xdv_pkg::PH_CMD;
							// A nonempty fill emits its result with the last byte
							if (run_cnt_q != 15'd0) begin
								fill_go = 1'b1;
								l.valid = 1'b0;
								l.emit  = 1'b0;
							end
						end
						xdv_pkg::PH_LITERAL: begin
							l_addr = wp_q;
							l.wr   = 1'b1;
							l.xr   = !copy_q;
							l.adv  = 1'b1;
							run_d  = run_cnt_q - 15'd1;
							if (run_cnt_q == 15'd1) begin
								phase_d = xdv_pkg::PH_CMD;
							end
						end
						xdv_pkg::PH_LONG_LO: begin
							lo_d    = s_tdata[7:0];
							phase_d = xdv_pkg::PH_LONG_HI;
						end
						xdv_pkg::PH_LONG_HI: begin
							phase_d = xdv_pkg::PH_CMD;
							if (long_n == 16'd0) begin
								// End of frame
								phase_d = xdv_pkg::PH_FRAME;
								l.done  = 1'b1;
							end else if (!long_n[15]) begin
								skip_go = 1'b1;
								skip_n  = long_n;
							end else if (long_n[14]) begin
								run_d   = {1'b0, long_n[13:0]};
								phase_d = xdv_pkg::PH_LFILL_VAL;
							end else begin
								run_d = {1'b0, long_n[13:0]};
								if (long_n[13:0] != 14'd0) begin
									phase_d = xdv_pkg::PH_LITERAL;
								end
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end else if (eng_q == xdv_pkg::ENG_FILL) begin
			// Walk one fill byte per cycle
			l.valid = 1'b1;
			l.emit  = (run_cnt_q == 15'd1);
			l.wr    = 1'b1;
			l.xr    = !copy_q;
			l.adv   = 1'b1;
			l.val   = fill_q;
			l_addr  = wp_q;
			run_d   = run_cnt_q - 15'd1;
		end
	end

	// Parser state and write position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= xdv_pkg::PH_FRAME;
			run_cnt_q <= 15'd0;
			fill_q    <= 8'd0;
			lo_q      <= 8'd0;
			wp_q      <= '0;
			col_q     <= 12'd0;
		end else begin
			phase_q   <= phase_d;
			run_cnt_q <= run_d;
			fill_q    <= fill_d;
			lo_q      <= lo_d;
			if (l.valid && l.adv) begin
				wp_q  <= wp_adv;
				col_q <= col_adv;
			end else if (skip_go || frame_go) begin
				wp_q  <= base_wp;
				col_q <= base_col;
			end else if (eng_q == xdv_pkg::ENG_ADD) begin
				// Back to the row start, down by whole rows, out to the new column
				wp_q  <= wp_q - AW'(col_q) + AW'(prod_q) + AW'(rem_q);
				col_q <= rem_q;
			end
		end
	end

	// One restoring divide step: total / width
	assign trial    = {rem_q, quo_q[15]};
	assign trial_ge = trial >= w;
	assign rem_next = trial_ge ? 12'(trial - w) : trial[11:0];

	// Engine sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_q     <= xdv_pkg::ENG_IDLE;
			div_cnt_q <= 4'd0;
		end else begin
			case (eng_q)
				xdv_pkg::ENG_IDLE: begin
					div_cnt_q <= 4'd0;
					if (fill_go) begin
						eng_q <= xdv_pkg::ENG_FILL;
					end else if (skip_go) begin
						eng_q <= xdv_pkg::ENG_DIV;
					end
				end
				xdv_pkg::ENG_FILL: begin
					if (run_cnt_q == 15'd1) begin
						eng_q <= xdv_pkg::ENG_IDLE;
					end
				end
				xdv_pkg::ENG_DIV: begin
					div_cnt_q <= div_cnt_q + 4'd1;
					if (div_cnt_q == 4'd15) begin
						eng_q <= xdv_pkg::ENG_MUL;
					end
				end
				xdv_pkg::ENG_MUL: eng_q <= xdv_pkg::ENG_ADD;
				xdv_pkg::ENG_ADD: eng_q <= xdv_pkg::ENG_IDLE;
				default:          eng_q <= xdv_pkg::ENG_IDLE;
			endcase
		end
	end

	// Divider and multiplier datapath
	always_ff @(posedge clk) begin
		if (eng_q == xdv_pkg::ENG_IDLE) begin
			quo_q <= skip_total;
			rem_q <= 12'd0;
		end else if (eng_q == xdv_pkg::ENG_DIV) begin
			quo_q <= {quo_q[14:0], trial_ge};
			rem_q <= rem_next;
		end
		if (eng_q == xdv_pkg::ENG_MUL) begin
			prod_q <= quo_q * pitch_q;
		end
	end

	// Frame store
	xdv_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_BYTES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (wdata),
		.raddr (l_addr),
		.rdata (ram_rdata)
	);

	// Access stage: read data is back, modify and write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			done_s1 <= 1'b0;
			wr_s1   <= 1'b0;
			xr_s1   <= 1'b0;
			rd_s1   <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			v_s1    <= l.valid;
			emit_s1 <= l.emit;
			done_s1 <= l.done;
			wr_s1   <= l.wr;
			xr_s1   <= l.xr;
			rd_s1   <= l.rd;
			fwd_v_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= l_addr;
		val_s1     <= l.val;
		fwd_addr_q <= addr_s1;
		fwd_data_q <= wdata;
	end

	// Forward the previous cycle's write over the stale read
	assign cur_byte = (fwd_v_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : ram_rdata;
	assign we       = v_s1 && wr_s1;
	assign wdata    = xr_s1 ? (cur_byte ^ val_s1) : val_s1;
	assign push     = v_s1 && emit_s1;

	// Result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= '0;
			q_rd_q  <= '0;
			q_cnt_q <= '0;
			pend_q  <= '0;
		end else begin
			if (push) begin
				q_wr_q <= q_wr_q + QPW'(1);
			end
			if (take) begin
				q_rd_q <= q_rd_q + QPW'(1);
			end
			q_cnt_q <= q_cnt_q + QCW'(push) - QCW'(take);
			pend_q  <= pend_q + QCW'(acc) - QCW'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[q_wr_q] <= '{last: done_s1, data: (rd_s1 ? cur_byte : 8'd0)};
		end
	end

	assign q_head   = q_mem[q_rd_q];
	assign m_tvalid = (q_cnt_q != '0);
	assign m_tdata  = q_head.data;
	assign m_tlast  = q_head.last;

	// Results owed never exceed the queue depth
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= QCW'(QD))
		else $error("more results owed than the queue holds");

	// Every owed result is queued, in the access stage, or held by a fill walk
	a_pend_track: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == q_cnt_q + QCW'(v_s1 && emit_s1) + QCW'(eng_q == xdv_pkg::ENG_FILL))
		else $error("result accounting out of step");

	// The engine runs only after a command has been fully parsed
	a_eng_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(eng_q != xdv_pkg::ENG_IDLE) |-> (phase_q == xdv_pkg::PH_CMD))
		else $error("engine busy outside command phase");

	// The divider hands over to the multiplier after its last step
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(eng_q == xdv_pkg::ENG_DIV && div_cnt_q == 4'd15) |=> (eng_q == xdv_pkg::ENG_MUL))
		else $error("divide sequence length wrong");

endmodule
